[rtl/assert_macros.svh]
// Assertion macros shared by the tuning-rule RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define IPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ipt assertion failed");
// Property that also covers the reset cycles.
`define IPT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ipt reset assertion failed");
`else
`define IPT_ASSERT(lbl, prop)
`define IPT_ASSERT_RST(lbl, prop)
`endif
`endif

[rtl/ipt_pkg.sv]
// Types, widths and constants of the IMC PID tuning-rule block.
package ipt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;
  localparam int RATIO_W    = 16;
  localparam int RATIO_FRAC = 8;
  localparam int GAIN_W     = WORD_WIDTH;
  localparam int TIME_W     = 31;
  localparam int UW         = WORD_WIDTH - 1;
  localparam int NUM_W      = TIME_W + 2;
  localparam int EPS_W      = TIME_W + RATIO_W - RATIO_FRAC;
  localparam int DEN_W      = EPS_W + 2;
  localparam int PROD_W     = 2 * TIME_W;
  localparam int T_W        = NUM_W + FRAC_BITS;
  localparam int KP_DW      = T_W + FRAC_BITS;
  localparam int KI_DW      = WORD_WIDTH + FRAC_BITS + 1;
  localparam int KD_PW      = WORD_WIDTH + TIME_W;
  localparam int CFG_IDX_W  = 2;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam int TDATA_USED = 2 * UW + 3 * WORD_WIDTH;
  localparam int TDATA_W    = ((TDATA_USED + 7) / 8) * 8;
  localparam int TUSER_W    = 3;

  localparam logic KIND_PID = 1'b0;
  localparam logic KIND_PI  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PLANT_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_CONST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME  = 2'd2;

  localparam logic [UW-1:0]         UMAX        = '1;
  localparam logic [WORD_WIDTH-1:0] KLIM_POS    = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic [WORD_WIDTH-1:0] KLIM_NEG    = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam int                    ECHO_TINY   = 999;
  localparam logic [UW-1:0]         ECHO_TINY_Q = UW'(ECHO_TINY * (2 ** FRAC_BITS));
  localparam logic [GAIN_W-1:0]     ONE_GAIN    = GAIN_W'(2 ** FRAC_BITS);
  localparam logic [TIME_W-1:0]     ONE_TIME    = TIME_W'(2 ** FRAC_BITS);

  typedef struct packed {
    logic [GAIN_W-1:0] plant_gain;
    logic [TIME_W-1:0] time_constant;
    logic [TIME_W-1:0] dead_time;
  } ipt_cfg_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               last;
  } ipt_job_t;

  typedef struct packed {
    logic             kind;
    logic             last;
    logic [UW-1:0]    epso;
    logic             eps_sat;
    logic             th_zero;
    logic             den_zero;
    logic [NUM_W-1:0] num;
  } ipt_sb_b_t;

  typedef struct packed {
    logic              kind;
    logic              last;
    logic [UW-1:0]     epso;
    logic [UW-1:0]     echo;
    logic              sat;
    logic              den_zero;
    logic [NUM_W-1:0]  num;
    logic [TIME_W-1:0] taud;
  } ipt_sb_c_t;

  typedef struct packed {
    logic                  kind;
    logic                  last;
    logic [UW-1:0]         epso;
    logic [UW-1:0]         echo;
    logic                  sat;
    logic                  num_zero;
    logic [WORD_WIDTH-1:0] kpm;
    logic [KD_PW-1:0]      kd_prod;
  } ipt_sb_d_t;

  function automatic logic [WORD_WIDTH-1:0] apply_sign(input logic [WORD_WIDTH-1:0] mag,
                                                       input logic neg);
    return neg ? (~mag + 1'b1) : mag;
  endfunction

endpackage

[rtl/ipt_front.sv]
// Front end: takes ratio transactions, drops them on zero gain, queues the rest.
`include "assert_macros.svh"
module ipt_front import ipt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [RATIO_W-1:0] s_axis_tdata,
  input  logic               s_axis_tlast,
  input  logic [GAIN_W-1:0]  plant_gain,
  input  logic               pop,
  output logic               job_valid,
  output ipt_job_t           job
);

  ipt_job_t           mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               take;
  logic               push;

  assign s_axis_tready = (count != (Q_PTR_W+1)'(Q_DEPTH));
  assign take          = s_axis_tvalid && s_axis_tready;
  // zero gain: transaction consumed, nothing queued
  assign push          = take && (plant_gain != '0);
  assign job_valid     = (count != '0);
  assign job           = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{ratio: s_axis_tdata, last: s_axis_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `IPT_ASSERT(a_pop_not_empty, pop |-> job_valid)
  `IPT_ASSERT(a_count_grows, push && !pop |=> count == $past(count) + 1'b1)

endmodule

[rtl/ipt_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module ipt_div #(
  parameter int DW = 8,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient
);

  logic [DW-1:0] word [1:DW];
  logic [VW-1:0] rem  [1:DW-1];
  logic [VW-1:0] dvs  [1:DW-1];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0] w_in;
    logic [VW-1:0] r_in;
    logic [VW-1:0] d_in;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    if (k == 0) begin : g_first
      assign w_in = dividend;
      assign r_in = '0;
      assign d_in = divisor;
    end else begin : g_rest
      assign w_in = word[k];
      assign r_in = rem[k];
      assign d_in = dvs[k];
    end

    assign trial = {r_in, w_in[DW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign fits  = (trial >= {1'b0, d_in});

    // dividend bits shift out at the top, quotient bits enter at the bottom
    always_ff @(posedge clk) begin
      if (ce) begin
        word[k+1] <= {w_in[DW-2:0], fits};
      end
    end

    if (k < DW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem[k+1] <= fits ? diff[VW-1:0] : trial[VW-1:0];
          dvs[k+1] <= d_in;
        end
      end
    end
  end

  assign quotient = word[DW];

endmodule

[rtl/ipt_delay.sv]
// Valid and sideband delay line that runs alongside a divider pipeline.
module ipt_delay #(
  parameter int LAT = 4,
  parameter int SW  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_vld,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [SW-1:0] out_side
);

  logic [LAT-1:0] vld;
  logic [SW-1:0]  side [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0] <= in_side;
      for (int i = 1; i < LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign out_vld  = vld[LAT-1];
  assign out_side = side[LAT-1];

endmodule

[rtl/ipt_back.sv]
// Back end: expands each queued ratio into PID and PI results through a divider pipeline.
`include "assert_macros.svh"
module ipt_back import ipt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ipt_cfg_t           cfg,
  input  logic               job_valid,
  input  ipt_job_t           job,
  output logic               pop,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [TUSER_W-1:0] m_axis_tuser,
  output logic               m_axis_tlast
);

  logic                      ce;
  logic                      phase;
  logic                      issue;
  logic                      neg;
  logic [GAIN_W-1:0]         kabs;
  logic [WORD_WIDTH-1:0]     klim;
  logic [TIME_W-1:0]         thf;
  logic [TIME_W+RATIO_W-1:0] eps_prod;

  // stage 1
  logic             s1_vld;
  logic             s1_kind;
  logic             s1_last;
  logic [EPS_W-1:0] s1_eps;

  // stage 2
  logic              s2_vld;
  ipt_sb_b_t         s2_sb;
  logic [EPS_W-1:0]  s2_eps;
  logic [DEN_W-1:0]  s2_den;
  logic [PROD_W-1:0] s2_tauth;
  logic [NUM_W-1:0]  num_c;
  logic [DEN_W-1:0]  den_c;

  // first divider group
  logic [PROD_W-1:0]            echo_dvd;
  logic [PROD_W-1:0]            t_dvd;
  logic [PROD_W-1:0]            q_echo;
  logic [PROD_W-1:0]            q_taud;
  logic [PROD_W-1:0]            q_t;
  logic                         b_vld;
  logic [$bits(ipt_sb_b_t)-1:0] b_side;
  ipt_sb_b_t                    b_sb;
  logic                         echo_big;
  ipt_sb_c_t                    c_in;

  // kp divider
  logic [KP_DW-1:0]             kp_dvd;
  logic [KP_DW-1:0]             q_kp;
  logic                         c_vld;
  logic [$bits(ipt_sb_c_t)-1:0] c_side;
  ipt_sb_c_t                    c_sb;
  logic                         kp_sat;
  logic [WORD_WIDTH-1:0]        kpm;
  ipt_sb_d_t                    d_in;

  // ki divider
  logic [KI_DW-1:0]             ki_dvd;
  logic [KI_DW-1:0]             q_ki;
  logic                         d_vld;
  logic [$bits(ipt_sb_d_t)-1:0] d_side;
  ipt_sb_d_t                    d_sb;
  logic                         ki_big;
  logic [WORD_WIDTH-1:0]        kim;
  logic [KD_PW-FRAC_BITS-1:0]   kd_full;
  logic                         kd_big;
  logic [WORD_WIDTH-1:0]        kdm;
  logic                         sat_all;

  // whole pipeline moves together whenever the output register can load
  assign ce    = !m_axis_tvalid || m_axis_tready;
  assign issue = ce && job_valid;
  assign pop   = issue && (phase == KIND_PI);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= KIND_PID;
    end else if (issue) begin
      phase <= ~phase;
    end
  end

  assign neg  = cfg.plant_gain[GAIN_W-1];
  assign kabs = neg ? (~cfg.plant_gain + 1'b1) : cfg.plant_gain;
  assign klim = neg ? KLIM_NEG : KLIM_POS;

  // epsilon = theta * r, dead time floored to one LSB
  assign thf      = (cfg.dead_time == '0) ? TIME_W'(1) : cfg.dead_time;
  assign eps_prod = thf * job.ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else if (ce) begin
      s1_vld <= issue;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_kind <= phase;
      s1_last <= job.last;
      s1_eps  <= eps_prod[TIME_W+RATIO_W-1:RATIO_FRAC];
    end
  end

  assign num_c = {1'b0, cfg.time_constant, 1'b0} + NUM_W'(cfg.dead_time);
  assign den_c = {1'b0, s1_eps, 1'b0} +
                 ((s1_kind == KIND_PI) ? DEN_W'(0) : DEN_W'(cfg.dead_time));

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_sb.kind     <= s1_kind;
      s2_sb.last     <= s1_last;
      s2_sb.epso     <= (s1_eps > EPS_W'(UMAX)) ? UMAX : s1_eps[UW-1:0];
      s2_sb.eps_sat  <= (s1_eps > EPS_W'(UMAX));
      s2_sb.th_zero  <= (cfg.dead_time == '0);
      s2_sb.den_zero <= (den_c == '0);
      s2_sb.num      <= num_c;
      s2_eps         <= s1_eps;
      s2_den         <= den_c;
      s2_tauth       <= cfg.time_constant * cfg.dead_time;
    end
  end

  assign echo_dvd = PROD_W'({s2_eps, {FRAC_BITS{1'b0}}});
  assign t_dvd    = PROD_W'({s2_sb.num, {FRAC_BITS{1'b0}}});

  ipt_div #(.DW(PROD_W), .VW(TIME_W)) u_div_echo (
    .clk(clk), .ce(ce), .dividend(echo_dvd), .divisor(cfg.dead_time), .quotient(q_echo)
  );

  ipt_div #(.DW(PROD_W), .VW(NUM_W)) u_div_taud (
    .clk(clk), .ce(ce), .dividend(s2_tauth), .divisor(s2_sb.num), .quotient(q_taud)
  );

  ipt_div #(.DW(PROD_W), .VW(DEN_W)) u_div_t (
    .clk(clk), .ce(ce), .dividend(t_dvd), .divisor(s2_den), .quotient(q_t)
  );

  ipt_delay #(.LAT(PROD_W), .SW($bits(ipt_sb_b_t))) u_dly_b (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(s2_vld), .in_side(s2_sb),
    .out_vld(b_vld), .out_side(b_side)
  );

  assign b_sb     = b_side;
  assign echo_big = (q_echo > PROD_W'(UMAX));

  always_comb begin
    c_in.kind     = b_sb.kind;
    c_in.last     = b_sb.last;
    c_in.epso     = b_sb.epso;
    c_in.echo     = b_sb.th_zero ? ECHO_TINY_Q : (echo_big ? UMAX : q_echo[UW-1:0]);
    c_in.sat      = b_sb.eps_sat || (!b_sb.th_zero && echo_big);
    c_in.den_zero = b_sb.den_zero;
    c_in.num      = b_sb.num;
    c_in.taud     = (b_sb.num == '0) ? '0 : q_taud[TIME_W-1:0];
  end

  assign kp_dvd = {q_t[T_W-1:0], {FRAC_BITS{1'b0}}};

  ipt_div #(.DW(KP_DW), .VW(GAIN_W)) u_div_kp (
    .clk(clk), .ce(ce), .dividend(kp_dvd), .divisor(kabs), .quotient(q_kp)
  );

  ipt_delay #(.LAT(KP_DW), .SW($bits(ipt_sb_c_t))) u_dly_c (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(b_vld), .in_side(c_in),
    .out_vld(c_vld), .out_side(c_side)
  );

  assign c_sb   = c_side;
  // zero denominator: kp pinned to the limit with the flag set
  assign kp_sat = c_sb.den_zero || (q_kp > KP_DW'(klim));
  assign kpm    = kp_sat ? klim : q_kp[WORD_WIDTH-1:0];

  always_comb begin
    d_in.kind     = c_sb.kind;
    d_in.last     = c_sb.last;
    d_in.epso     = c_sb.epso;
    d_in.echo     = c_sb.echo;
    d_in.sat      = c_sb.sat || kp_sat;
    d_in.num_zero = (c_sb.num == '0);
    d_in.kpm      = kpm;
    d_in.kd_prod  = kpm * c_sb.taud;
  end

  assign ki_dvd = {kpm, {(FRAC_BITS+1){1'b0}}};

  ipt_div #(.DW(KI_DW), .VW(NUM_W)) u_div_ki (
    .clk(clk), .ce(ce), .dividend(ki_dvd), .divisor(c_sb.num), .quotient(q_ki)
  );

  ipt_delay #(.LAT(KI_DW), .SW($bits(ipt_sb_d_t))) u_dly_d (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(c_vld), .in_side(d_in),
    .out_vld(d_vld), .out_side(d_side)
  );

  assign d_sb    = d_side;
  assign ki_big  = (q_ki > KI_DW'(klim));
  assign kim     = d_sb.num_zero ? '0 : (ki_big ? klim : q_ki[WORD_WIDTH-1:0]);
  assign kd_full = d_sb.kd_prod[KD_PW-1:FRAC_BITS];
  assign kd_big  = (kd_full > (KD_PW-FRAC_BITS)'(klim));
  assign kdm     = (d_sb.kind == KIND_PI) ? '0 : (kd_big ? klim : kd_full[WORD_WIDTH-1:0]);
  assign sat_all = d_sb.sat || (!d_sb.num_zero && ki_big) ||
                   ((d_sb.kind == KIND_PID) && kd_big);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      m_axis_tvalid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_axis_tdata <= {{(TDATA_W-TDATA_USED){1'b0}},
                       apply_sign(kdm, neg), apply_sign(kim, neg),
                       apply_sign(d_sb.kpm, neg), d_sb.echo, d_sb.epso};
      m_axis_tuser <= {d_sb.kind == KIND_PI, sat_all, d_sb.kind};
      m_axis_tlast <= (d_sb.kind == KIND_PI) && d_sb.last;
    end
  end

  `IPT_ASSERT(a_pi_follows_pid, m_axis_tvalid && m_axis_tready && m_axis_tuser[0] == KIND_PID |=> m_axis_tvalid && m_axis_tuser[0] == KIND_PI)
  `IPT_ASSERT_RST(a_reset_idle, rst |=> !m_axis_tvalid && !s1_vld && !s2_vld)

endmodule

[rtl/imc_pid_tuning_rule_core.sv]
// Top level of the IMC PID tuning-rule block for a first-order-plus-dead-time plant.
//
// Use:
//   cfg_*     : register writes, index 0 plant gain (signed Q16.16), 1 time constant,
//               2 dead time (unsigned Q15.16). Always ready; index 3 is ignored.
//               Write only while the block is idle.
//   s_axis_*  : one transaction per closed-loop ratio (Q8.8), tlast marks the last
//               ratio of a tuning list.
//   m_axis_*  : two transactions per ratio, PID entry first, improved PI entry second.
// Sharing: the two results of a ratio share one datapath that issues one result per
//   cycle unless the output stalls. Input is queued (4 deep) while results drain.
// Path: a ratio passes stage 1, stage 2, the divider chain (62 + 65 + 49 one-bit
//   stages) and the output register; the PI entry follows its PID entry directly.
// With zero plant gain a ratio is consumed and gives no result.
// Reset (rst, synchronous) empties the queue and pipeline and loads 1.0 into all
//   three registers. When a result waits with m_axis_tready low the whole pipeline
//   holds; the input keeps taking ratios until the queue is full.
module imc_pid_tuning_rule_core import ipt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [RATIO_W-1:0]   s_axis_tdata,   // [15:0] closed_loop_ratio
  input  logic                 s_axis_tlast,   // last_ratio
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [30:0] epsilon_value, [61:31] ratio_echo, [93:62] prop_gain,
  // [125:94] integ_gain, [157:126] deriv_gain, [159:158] zero
  output logic [TDATA_W-1:0]   m_axis_tdata,
  // [0] controller_kind, [1] saturated, [2] end_of_pair
  output logic [TUSER_W-1:0]   m_axis_tuser,
  output logic                 m_axis_tlast    // end_of_list
);

  ipt_cfg_t cfg;
  logic     job_valid;
  ipt_job_t job;
  logic     pop;

  assign cfg_ready = 1'b1;

  // register file; upper data bits beyond a register's width are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plant_gain    <= ONE_GAIN;
      cfg.time_constant <= ONE_TIME;
      cfg.dead_time     <= ONE_TIME;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PLANT_GAIN: cfg.plant_gain    <= cfg_data;
        REG_TIME_CONST: cfg.time_constant <= cfg_data[TIME_W-1:0];
        REG_DEAD_TIME:  cfg.dead_time     <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  ipt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .plant_gain   (cfg.plant_gain),
    .pop          (pop),
    .job_valid    (job_valid),
    .job          (job)
  );

  ipt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (job_valid),
    .job          (job),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

[bench/tb_imc_pid_tuning_rule_core.sv]
// Self-checking bench for the IMC PID tuning-rule core: table, directed plant cases, then random ratios.
`timescale 1ns / 1ps
module tb_imc_pid_tuning_rule_core;
  import ipt_pkg::*;

  // Spare register index, a write here must leave the registers unchanged
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 250;   // above the result latency
  localparam int STALL_LIMIT  = 20000; // cycles with no transaction at all

  typedef struct packed {
    logic                  kind;
    logic [UW-1:0]         eps;
    logic [UW-1:0]         echo;
    logic [WORD_WIDTH-1:0] kp;
    logic [WORD_WIDTH-1:0] ki;
    logic [WORD_WIDTH-1:0] kd;
    logic                  sat;
    logic                  pair_end;
    logic                  list_end;
  } gain_set_t;

  // One directed row: ratio, tuning-list mark, and optionally a hand-worked pair
  typedef struct {
    logic [RATIO_W-1:0] ratio;
    logic               last;
    bit                 typed;
    gain_set_t          pid;
    gain_set_t          pi;
  } ratio_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [RATIO_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  // Bench copy of the plant registers
  logic [GAIN_W-1:0] plant_k;
  logic [TIME_W-1:0] plant_tau;
  logic [TIME_W-1:0] plant_theta;

  gain_set_t gain_sets_due[$];
  int  mismatches = 0;
  bit  steady_sink = 1'b0; // long stretch with the sink never stalling
  int  quiet_cycles = 0;

  imc_pid_tuning_rule_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // floor(a * 2^s / b), clipped to lim; zero divisor clips too
  function automatic logic [63:0] div_scaled(input logic [63:0] a, input logic [63:0] b,
                                             input int s, input logic [63:0] lim,
                                             inout bit sat);
    logic [127:0] q;
    if (b == 0) begin
      sat = 1'b1;
      return lim;
    end
    q = ({64'd0, a} << s) / {64'd0, b};
    if (q > {64'd0, lim}) begin
      sat = 1'b1;
      return lim;
    end
    return q[63:0];
  endfunction

  // floor(a * b / 2^s), clipped to lim
  function automatic logic [63:0] mul_scaled(input logic [63:0] a, input logic [63:0] b,
                                             input int s, input logic [63:0] lim,
                                             inout bit sat);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    if (p > {64'd0, lim}) begin
      sat = 1'b1;
      return lim;
    end
    return p[63:0];
  endfunction

  function automatic logic [WORD_WIDTH-1:0] signed_gain(input logic [63:0] mag,
                                                        input bit neg);
    logic [WORD_WIDTH-1:0] m;
    m = mag[WORD_WIDTH-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

  // PID and improved-PI gains for one ratio under the current plant registers;
  // returns 0 when the plant gain is zero (item swallowed)
  function automatic bit tune_gains(input logic [RATIO_W-1:0] r, input logic last,
                                    output gain_set_t pid, output gain_set_t pi);
    logic [63:0] umax, kabs, klim, tau, th, thf, eps, epso, echo, num, d, taud;
    logic [63:0] kpm, kim, kdm;
    bit neg, shared, s;
    umax = (64'd1 << UW) - 1;
    neg  = plant_k[GAIN_W-1];
    kabs = neg ? ((64'd1 << GAIN_W) - plant_k) : {32'd0, plant_k};
    pid = '0;
    pi  = '0;
    if (kabs == 0) return 1'b0;
    klim = neg ? umax + 1 : umax;
    tau = plant_tau;
    th  = plant_theta;
    shared = 1'b0;
    thf = (th == 0) ? 64'd1 : th;
    eps = (thf * r) >> RATIO_FRAC;
    if (eps > umax) begin
      epso = umax;
      shared = 1'b1;
    end else begin
      epso = eps;
    end
    // tiny dead time: echo is the fixed 999.0 marker
    if (th == 0) echo = (64'(ECHO_TINY) > (umax >> FRAC_BITS)) ? umax
                        : (64'(ECHO_TINY) << FRAC_BITS);
    else echo = div_scaled(eps, th, FRAC_BITS, umax, shared);
    num  = 2 * tau + th;
    d    = 2 * eps + th;
    taud = (num != 0) ? (tau * th) / num : 64'd0;

    s = shared;
    if (d == 0) begin
      s = 1'b1;
      kpm = klim;
    end else begin
      kpm = div_scaled(div_scaled(num, d, FRAC_BITS, 64'd1 << 62, s), kabs,
                       FRAC_BITS, klim, s);
    end
    kim = (num != 0) ? div_scaled(kpm, num, FRAC_BITS + 1, klim, s) : 64'd0;
    kdm = mul_scaled(kpm, taud, FRAC_BITS, klim, s);
    pid = '{KIND_PID, epso[UW-1:0], echo[UW-1:0], signed_gain(kpm, neg),
            signed_gain(kim, neg), signed_gain(kdm, neg), s, 1'b0, 1'b0};

    s = shared;
    if (eps == 0) begin
      s = 1'b1;
      kpm = klim;
    end else begin
      kpm = div_scaled(div_scaled(num, 2 * eps, FRAC_BITS, 64'd1 << 62, s), kabs,
                       FRAC_BITS, klim, s);
    end
    kim = (num != 0) ? div_scaled(kpm, num, FRAC_BITS + 1, klim, s) : 64'd0;
    pi = '{KIND_PI, epso[UW-1:0], echo[UW-1:0], signed_gain(kpm, neg),
           signed_gain(kim, neg), '0, s, 1'b1, last};
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Appends one expected result to the scoreboard
  task automatic expect_set(input gain_set_t g);
    gain_sets_due = {gain_sets_due, g};
  endtask

  // Register write over the config channel; bench copy follows the write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PLANT_GAIN: plant_k = val;
      REG_TIME_CONST: plant_tau = val[TIME_W-1:0];
      REG_DEAD_TIME:  plant_theta = val[TIME_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_plant(input logic [GAIN_W-1:0] k, input logic [GAIN_W-1:0] tau,
                            input logic [GAIN_W-1:0] th);
    write_reg(REG_PLANT_GAIN, k);
    write_reg(REG_TIME_CONST, tau);
    write_reg(REG_DEAD_TIME, th);
  endtask

  // Block is idle once every result is back and the drain wait has run out;
  // zero-gain items are dropped at the input and leave nothing in the pipeline
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (gain_sets_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One ratio transaction; typed rows override the predictor
  task automatic send_ratio(input ratio_row_t row, input bit may_idle);
    gain_set_t pid, pi;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.ratio;
    s_axis_tlast  <= row.last;
    do @(posedge clk); while (!s_axis_tready);
    if (row.typed) begin
      expect_set(row.pid);
      expect_set(row.pi);
    end else if (tune_gains(row.ratio, row.last, pid, pi)) begin
      expect_set(pid);
      expect_set(pi);
    end
    if (may_idle && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic ratio_row_t plain_row(input logic [RATIO_W-1:0] r, input logic last);
    ratio_row_t row;
    row = '{r, last, 1'b0, '0, '0};
    return row;
  endfunction

  // Random register value from a mix of small, large and extreme magnitudes
  function automatic logic [GAIN_W-1:0] pick_reg(input bit allow_zero);
    case ($urandom_range(7))
      0: return allow_zero ? '0 : GAIN_W'(1);
      1: return GAIN_W'($urandom_range(255, 1));
      2: return $urandom;
      3: return {1'b0, 31'h7FFFFFFF};
      4: return GAIN_W'($urandom_range(20 << FRAC_BITS, 1 << (FRAC_BITS - 4)));
      default: return GAIN_W'($urandom_range(4 << FRAC_BITS, 1 << (FRAC_BITS - 2)));
    endcase
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio();
    case ($urandom_range(5))
      0: return RATIO_W'($urandom_range(3));
      1: return RATIO_W'($urandom);
      2: return '1;
      default: return RATIO_W'($urandom_range(1024, 64));
    endcase
  endfunction

  // Sink holds tready low about 38 percent of the time, except during the steady stretch
  always @(posedge clk) begin
    m_axis_tready <= steady_sink || ($urandom_range(99) >= 38);
  end

  // Result checker: each transaction against the oldest expectation
  always @(posedge clk) begin
    gain_set_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser[0], m_axis_tdata[30:0], m_axis_tdata[61:31],
              m_axis_tdata[93:62], m_axis_tdata[125:94], m_axis_tdata[157:126],
              m_axis_tuser[1], m_axis_tuser[2], m_axis_tlast};
      if (gain_sets_due.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = gain_sets_due.pop_front();
        if (got.kind != want.kind)
          report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
        if (got.eps != want.eps)
          report_mismatch($sformatf("epsilon %h want %h", got.eps, want.eps));
        if (got.echo != want.echo)
          report_mismatch($sformatf("ratio echo %h want %h", got.echo, want.echo));
        if (got.kp != want.kp)
          report_mismatch($sformatf("kp %h want %h", got.kp, want.kp));
        if (got.ki != want.ki)
          report_mismatch($sformatf("ki %h want %h", got.ki, want.ki));
        if (got.kd != want.kd)
          report_mismatch($sformatf("kd %h want %h", got.kd, want.kd));
        if (got.sat != want.sat)
          report_mismatch($sformatf("saturated %0d want %0d", got.sat, want.sat));
        if (got.pair_end != want.pair_end)
          report_mismatch($sformatf("end of pair %0d want %0d", got.pair_end,
                                    want.pair_end));
        if (got.list_end != want.list_end)
          report_mismatch($sformatf("end of list %0d want %0d", got.list_end,
                                    want.list_end));
      end
    end
  end

  // Watchdog: ends the run after too long with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ratio_row_t table_rows[$];
    ratio_row_t row;
    plant_k     = ONE_GAIN;
    plant_tau   = ONE_TIME;
    plant_theta = ONE_TIME;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset, ratio 1.0 with k = tau = theta = 1.0 works out by hand:
    // PID kp 1.0, ki 2/3, kd 1/3; PI kp 1.5, ki 1.0
    row = '{16'h0100, 1'b1, 1'b1,
            '{KIND_PID, 31'h10000, 31'h10000, 32'h10000, 32'hAAAA, 32'h5555,
              1'b0, 1'b0, 1'b0},
            '{KIND_PI, 31'h10000, 31'h10000, 32'h18000, 32'h10000, 32'h0,
              1'b0, 1'b1, 1'b1}};
    table_rows = {table_rows, row};
    table_rows = {table_rows, plain_row(16'h0000, 1'b0)}; // zero epsilon, PI divides by 0
    table_rows = {table_rows, plain_row(16'h0001, 1'b0)};
    table_rows = {table_rows, plain_row(16'hFFFF, 1'b1)};
    table_rows = {table_rows, plain_row(16'h8000, 1'b0)};
    table_rows = {table_rows, plain_row(16'h5555, 1'b1)};
    table_rows = {table_rows, plain_row(16'hAAAA, 1'b0)};
    table_rows = {table_rows, plain_row(16'h00FF, 1'b1)};
    foreach (table_rows[i]) send_ratio(table_rows[i], 1'b0);
    wait_idle();

    // Negative gain and the spare index, which must be ignored
    load_plant(32'hFFFF0000, 32'h00030000, 32'h00008000);
    write_reg(REG_SPARE, 32'h12345678);
    send_ratio(plain_row(16'h0100, 1'b0), 1'b0);
    send_ratio(plain_row(16'h0000, 1'b1), 1'b0);
    wait_idle();
    // Zero dead time: dead time floors to one LSB, echo is 999.0;
    // zero tau too, so ki and kd drop to zero
    load_plant(32'h00010000, 32'h0, 32'h0);
    send_ratio(plain_row(16'h0100, 1'b1), 1'b0);
    send_ratio(plain_row(16'h0000, 1'b0), 1'b0);
    send_ratio(plain_row(16'hFFFF, 1'b1), 1'b0);
    wait_idle();
    // Extremes: most negative gain, bits above register width set
    load_plant(32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_ratio(plain_row(16'hFFFF, 1'b0), 1'b0);
    send_ratio(plain_row(16'h0001, 1'b1), 1'b0);
    wait_idle();
    // Smallest gain magnitudes, saturating kp
    load_plant(32'h00000001, 32'h00000001, 32'h00000001);
    send_ratio(plain_row(16'h0100, 1'b0), 1'b0);
    wait_idle();
    write_reg(REG_PLANT_GAIN, 32'hFFFFFFFF);
    send_ratio(plain_row(16'h0002, 1'b1), 1'b0);
    wait_idle();
    // Zero gain: items swallowed, tuning-list mark lost
    write_reg(REG_PLANT_GAIN, 32'h0);
    send_ratio(plain_row(16'h0100, 1'b1), 1'b0);
    send_ratio(plain_row(16'h0200, 1'b0), 1'b0);
    wait_idle();

    // Random phases; a couple of them run with the sink never stalling
    for (int phase = 0; phase < 10; phase++) begin
      logic [GAIN_W-1:0] k;
      k = pick_reg(phase == 7);
      if ($urandom_range(1)) k = ~k + 1'b1;
      load_plant(k, pick_reg(1'b1), pick_reg(1'b1));
      steady_sink = (phase == 3 || phase == 4);
      for (int n = 0; n < 155; n++)
        send_ratio(plain_row(pick_ratio(), $urandom_range(3) == 0),
                   !(phase == 3 || phase == 4));
      wait_idle();
    end
    steady_sink = 1'b0;

    if (mismatches == 0 && gain_sets_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[imc_pid_tuning_rule_core.f]
+incdir+rtl
rtl/ipt_pkg.sv
rtl/ipt_front.sv
rtl/ipt_div.sv
rtl/ipt_delay.sv
rtl/ipt_back.sv
rtl/imc_pid_tuning_rule_core.sv
bench/tb_imc_pid_tuning_rule_core.sv
